FILE: src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared command and status types between the max-flow controller and datapath
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int FLOW_W = 26;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LATCH,
        OP_A_RD,
        OP_A_LNK,
        OP_B_RD,
        OP_B_LNK,
        OP_INIT,
        OP_START,
        OP_PUSH,
        OP_EXAM,
        OP_POP,
        OP_POP2,
        OP_EVAL,
        OP_AUG_RD,
        OP_AUG_F1,
        OP_AUG_F2,
        OP_AUG_F3,
        OP_OUT
    } mfd_op_t;

    typedef struct packed {
        logic full;      // edge storage has no room for another pair
        logic in_last;   // last_edge on the input ports
        logic last;      // latched last_edge
        logic same;      // source equals sink
        logic cur_none;  // top of stack has run out of arcs
        logic sp_one;    // popping empties the stack
        logic take;      // arc has residual and head not visited
        logic hit_sink;  // arc head is the sink
        logic room;      // stack can take another node
        logic aug_last;  // last path arc being updated
    } mfd_status_t;

endpackage

FILE: src/max_flow_dfs_augment.sv
// ----------------------------------------------------------------------------
// max_flow_dfs_augment
// edge word: latched, then stored and linked as a forward and a reverse arc
//   (only latched and flagged dropped when storage is full); busy stays high
//   meanwhile, and the last edge starts the full solve, then the result strobe
// solve: exam and eval per arc examined, push per node pushed, exam, pop and
//   pop2 per node popped, aug read and flow updates per path arc augmented
// reset: graph empty, visited map clear, config at node_count 256, source 0,
//   sink 255; the receiver cannot stall, so done lasts exactly one cycle
// ----------------------------------------------------------------------------
module max_flow_dfs_augment
    import mfd_pkg::*;
#(
    parameter int NODE_LIMIT    = 256,
    parameter int EDGE_LIMIT    = 1024,
    parameter int CAPACITY_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        edge_from,
    input  logic [7:0]        edge_to,
    input  logic [15:0]       edge_capacity,
    input  logic              last_edge,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    output logic              done,
    output logic [FLOW_W-1:0] total_flow,
    output logic              edges_dropped
);

    mfd_op_t     cmd;
    mfd_status_t status;

    mfd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .status(status),
        .cmd(cmd), .busy(busy)
    );

    mfd_dp #(
        .NODE_LIMIT(NODE_LIMIT),
        .EDGE_LIMIT(EDGE_LIMIT),
        .CAPACITY_BITS(CAPACITY_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .edge_from(edge_from), .edge_to(edge_to),
        .edge_capacity(edge_capacity), .last_edge(last_edge),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .total_flow(total_flow), .edges_dropped(edges_dropped)
    );

endmodule

FILE: src/mfd_ram.sv
// ----------------------------------------------------------------------------
// mfd_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl
// Sequencer for edge loading, depth-first augmenting searches and result
// ----------------------------------------------------------------------------
module mfd_ctrl
    import mfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  mfd_status_t status,
    output mfd_op_t     cmd,
    output logic        busy
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_LNK,
        ST_B_RD,
        ST_B_LNK,
        ST_INIT,
        ST_START,
        ST_PUSH,
        ST_EXAM,
        ST_POP,
        ST_POP2,
        ST_EVAL,
        ST_AUG_RD,
        ST_AUG_F1,
        ST_AUG_F2,
        ST_AUG_F3,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = OP_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd = OP_LATCH;
                    if (!status.full)
                        state_next = ST_A_RD;
                    else if (status.in_last)
                        state_next = ST_INIT;
                end
            end
            ST_A_RD:   begin cmd = OP_A_RD;  state_next = ST_A_LNK; end
            ST_A_LNK:  begin cmd = OP_A_LNK; state_next = ST_B_RD;  end
            ST_B_RD:   begin cmd = OP_B_RD;  state_next = ST_B_LNK; end
            ST_B_LNK:
            begin
                cmd        = OP_B_LNK;
                state_next = status.last ? ST_INIT : ST_IDLE;
            end
            ST_INIT:
            begin
                cmd        = OP_INIT;
                state_next = status.same ? ST_OUT : ST_START;
            end
            ST_START:  begin cmd = OP_START; state_next = ST_PUSH; end
            ST_PUSH:   begin cmd = OP_PUSH;  state_next = ST_EXAM; end
            ST_EXAM:
            begin
                cmd = OP_EXAM;
                priority if (status.cur_none && status.sp_one)
                    state_next = ST_OUT;
                else if (status.cur_none)
                    state_next = ST_POP;
                else
                    state_next = ST_EVAL;
            end
            ST_POP:    begin cmd = OP_POP;  state_next = ST_POP2; end
            ST_POP2:   begin cmd = OP_POP2; state_next = ST_EXAM; end
            ST_EVAL:
            begin
                cmd = OP_EVAL;
                priority if (status.take && status.hit_sink)
                    state_next = ST_AUG_RD;
                else if (status.take && status.room)
                    state_next = ST_PUSH;
                else
                    state_next = ST_EXAM;
            end
            ST_AUG_RD: begin cmd = OP_AUG_RD; state_next = ST_AUG_F1; end
            ST_AUG_F1: begin cmd = OP_AUG_F1; state_next = ST_AUG_F2; end
            ST_AUG_F2: begin cmd = OP_AUG_F2; state_next = ST_AUG_F3; end
            ST_AUG_F3:
            begin
                cmd        = OP_AUG_F3;
                state_next = status.aug_last ? ST_START : ST_AUG_RD;
            end
            ST_OUT:    begin cmd = OP_OUT; state_next = ST_IDLE; end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: src/mfd_dp.sv
// ----------------------------------------------------------------------------
// mfd_dp
// Arc and node memories, search stack, visited map and flow accumulation
// ----------------------------------------------------------------------------
module mfd_dp
    import mfd_pkg::*;
#(
    parameter int NODE_LIMIT    = 256,
    parameter int EDGE_LIMIT    = 1024,
    parameter int CAPACITY_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mfd_op_t           cmd,
    output mfd_status_t       status,
    input  logic [7:0]        edge_from,
    input  logic [7:0]        edge_to,
    input  logic [15:0]       edge_capacity,
    input  logic              last_edge,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    output logic              done,
    output logic [FLOW_W-1:0] total_flow,
    output logic              edges_dropped
);

    localparam int NB    = $clog2(NODE_LIMIT);
    localparam int SLOTS = 2 * EDGE_LIMIT;
    localparam int AB    = $clog2(SLOTS);
    localparam int PW    = AB + 1;
    localparam int CW    = (CAPACITY_BITS < 16) ? CAPACITY_BITS : 16;
    localparam int FW    = CW + 1;
    localparam int RW    = CW + 2;
    localparam int SW    = NB + 1;

    localparam logic [PW-1:0] ARC_NONE = PW'(SLOTS);
    localparam logic [FW-1:0] BN_MAX   = '1;
    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_SINK       = 2'd2;

    function automatic logic [NB-1:0] node_mod(input logic [7:0] v);
        logic [11:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[10:0], v[i]};
            if (r >= 12'(NODE_LIMIT))
                r = r - 12'(NODE_LIMIT);
        end
        return r[NB-1:0];
    endfunction

    // control state
    logic [8:0]            node_count_reg, node_count_next;
    logic [7:0]            source_reg, source_next;
    logic [7:0]            sink_reg, sink_next;
    logic [PW-1:0]         arc_count_reg, arc_count_next;
    logic [FLOW_W-1:0]     flow_sum_reg, flow_sum_next;
    logic                  overflow_reg, overflow_next;
    logic [NODE_LIMIT-1:0] valid_reg, valid_next;
    logic [NODE_LIMIT-1:0] visited_reg, visited_next;
    logic [SW-1:0]         sp_reg, sp_next;
    logic [SW-1:0]         k_reg, k_next;
    logic                  done_reg, done_next;

    // payload
    logic [NB-1:0]     from_reg, from_next;
    logic [NB-1:0]     to_reg, to_next;
    logic [CW-1:0]     cap_reg, cap_next;
    logic              last_reg, last_next;
    logic [PW-1:0]     cur_reg, cur_next;
    logic [FW-1:0]     top_bn_reg, top_bn_next;
    logic [NB-1:0]     pn_reg, pn_next;
    logic [FW-1:0]     pbn_reg, pbn_next;
    logic [FW-1:0]     aug_bn_reg, aug_bn_next;
    logic [AB-1:0]     e_reg, e_next;
    logic [FLOW_W-1:0] total_reg, total_next;
    logic              dropped_reg, dropped_next;

    // memory ports
    logic          tgt_we, cap_we, flw_we, nxt_we, fst_we, lst_we, sc_we, sb_we;
    logic [AB-1:0] arc_waddr, flw_waddr, nxt_waddr;
    logic [AB-1:0] arc_raddr, flw_raddr, nxt_raddr;
    logic [NB-1:0] tgt_wdata;
    logic [CW-1:0] cap_wdata;
    logic [FW-1:0] flw_wdata;
    logic [PW-1:0] nxt_wdata;
    logic [NB-1:0] fst_waddr, fst_raddr, lst_waddr, lst_raddr;
    logic [AB-1:0] fst_wdata, lst_wdata;
    logic [NB-1:0] sk_waddr, sk_raddr;
    logic [PW-1:0] sc_wdata;
    logic [NB-1:0] tgt_rd;
    logic [CW-1:0] cap_rd;
    logic [FW-1:0] flw_rd;
    logic [PW-1:0] nxt_rd;
    logic [AB-1:0] fst_rd, lst_rd;
    logic [PW-1:0] sc_rd;
    logic [FW-1:0] sb_rd;

    logic [NB-1:0]         src, snk;
    logic [AB-1:0]         arc_a, arc_b;
    logic [AB+1:0]         pair_end;
    logic                  full;
    logic signed [RW-1:0]  resid;
    logic [FW-1:0]         resid_u, bn_min;
    logic [NB-1:0]         top_idx, pop_idx;
    logic [NODE_LIMIT-1:0] clear_mask;
    logic [FLOW_W:0]       sum_wide;
    logic [PW-1:0]         push_cur;

    assign src      = node_mod(source_reg);
    assign snk      = node_mod(sink_reg);
    assign arc_a    = arc_count_reg[AB-1:0];
    assign arc_b    = arc_a | AB'(1);
    assign pair_end = {1'b0, arc_count_reg} + (AB+2)'(2);
    assign full     = pair_end > (AB+2)'(SLOTS);
    assign resid    = $signed({2'b00, cap_rd}) - $signed({flw_rd[FW-1], flw_rd});
    assign resid_u  = resid[FW-1:0];
    assign bn_min   = (resid_u < top_bn_reg) ? resid_u : top_bn_reg;
    assign top_idx  = NB'(sp_reg - SW'(1));
    assign pop_idx  = NB'(sp_reg - SW'(2));
    assign sum_wide = {1'b0, flow_sum_reg} + (FLOW_W+1)'(aug_bn_reg);
    assign push_cur = valid_reg[pn_reg] ? {1'b0, fst_rd} : ARC_NONE;

    always_comb
    begin
        for (int i = 0; i < NODE_LIMIT; i++)
            clear_mask[i] = (i < int'(node_count_reg));
    end

    assign status.full     = full;
    assign status.in_last  = last_edge;
    assign status.last     = last_reg;
    assign status.same     = (src == snk);
    assign status.cur_none = (cur_reg == ARC_NONE);
    assign status.sp_one   = (sp_reg == SW'(1));
    assign status.take     = (resid > 0) && !visited_reg[tgt_rd];
    assign status.hit_sink = (tgt_rd == snk);
    assign status.room     = (sp_reg < SW'(NODE_LIMIT));
    assign status.aug_last = (k_reg == sp_reg - SW'(1));

    always_comb
    begin
        node_count_next = node_count_reg;
        source_next     = source_reg;
        sink_next       = sink_reg;
        arc_count_next  = arc_count_reg;
        flow_sum_next   = flow_sum_reg;
        overflow_next   = overflow_reg;
        valid_next      = valid_reg;
        visited_next    = visited_reg;
        sp_next         = sp_reg;
        k_next          = k_reg;
        done_next       = 1'b0;
        from_next       = from_reg;
        to_next         = to_reg;
        cap_next        = cap_reg;
        last_next       = last_reg;
        cur_next        = cur_reg;
        top_bn_next     = top_bn_reg;
        pn_next         = pn_reg;
        pbn_next        = pbn_reg;
        aug_bn_next     = aug_bn_reg;
        e_next          = e_reg;
        total_next      = total_reg;
        dropped_next    = dropped_reg;

        tgt_we = 1'b0; cap_we = 1'b0; flw_we = 1'b0; nxt_we = 1'b0;
        fst_we = 1'b0; lst_we = 1'b0; sc_we = 1'b0; sb_we = 1'b0;
        arc_waddr = arc_a;
        flw_waddr = arc_a;
        nxt_waddr = arc_a;
        arc_raddr = cur_reg[AB-1:0];
        flw_raddr = cur_reg[AB-1:0];
        nxt_raddr = cur_reg[AB-1:0];
        tgt_wdata = to_reg;
        cap_wdata = cap_reg;
        flw_wdata = '0;
        nxt_wdata = ARC_NONE;
        fst_waddr = from_reg;
        fst_raddr = src;
        fst_wdata = arc_a;
        lst_waddr = from_reg;
        lst_raddr = from_reg;
        lst_wdata = arc_a;
        sk_waddr  = top_idx;
        sk_raddr  = pop_idx;
        sc_wdata  = cur_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_next = cfg_data;
                CFG_SOURCE:     source_next     = cfg_data[7:0];
                CFG_SINK:       sink_next       = cfg_data[7:0];
                default:        ;
            endcase
        end

        unique case (cmd)
            OP_IDLE: ;
            OP_LATCH:
            begin
                from_next = node_mod(edge_from);
                to_next   = node_mod(edge_to);
                cap_next  = edge_capacity[CW-1:0];
                last_next = last_edge;
                if (full)
                    overflow_next = 1'b1;
            end
            OP_A_RD:
            begin
                tgt_we = 1'b1; cap_we = 1'b1; flw_we = 1'b1; nxt_we = 1'b1;
            end
            OP_A_LNK:
            begin
                if (valid_reg[from_reg])
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = lst_rd;
                    nxt_wdata = {1'b0, arc_a};
                end
                else
                begin
                    fst_we = 1'b1;
                end
                lst_we               = 1'b1;
                valid_next[from_reg] = 1'b1;
            end
            OP_B_RD:
            begin
                tgt_we = 1'b1; cap_we = 1'b1; flw_we = 1'b1; nxt_we = 1'b1;
                arc_waddr = arc_b;
                flw_waddr = arc_b;
                nxt_waddr = arc_b;
                tgt_wdata = from_reg;
                cap_wdata = '0;
                lst_raddr = to_reg;
            end
            OP_B_LNK:
            begin
                fst_waddr = to_reg;
                fst_wdata = arc_b;
                lst_waddr = to_reg;
                lst_wdata = arc_b;
                if (valid_reg[to_reg])
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = lst_rd;
                    nxt_wdata = {1'b0, arc_b};
                end
                else
                begin
                    fst_we = 1'b1;
                end
                lst_we             = 1'b1;
                valid_next[to_reg] = 1'b1;
                arc_count_next     = arc_count_reg + PW'(2);
            end
            OP_INIT:
            begin
                flow_sum_next = '0;
                // no search runs when source equals sink, so marks stay
                if (!status.same)
                    visited_next = visited_reg & ~clear_mask;
            end
            OP_START:
            begin
                sp_next   = '0;
                pn_next   = src;
                pbn_next  = BN_MAX;
                fst_raddr = src;
            end
            OP_PUSH:
            begin
                sc_we               = 1'b1;
                sb_we               = 1'b1;
                sk_waddr            = sp_reg[NB-1:0];
                sc_wdata            = push_cur;
                cur_next            = push_cur;
                top_bn_next         = pbn_reg;
                visited_next[pn_reg] = 1'b1;
                sp_next             = sp_reg + SW'(1);
            end
            OP_EXAM:
            begin
                if (cur_reg == ARC_NONE)
                    sp_next = sp_reg - SW'(1);
            end
            OP_POP:
            begin
                top_bn_next = sb_rd;
                nxt_raddr   = sc_rd[AB-1:0];
            end
            OP_POP2:
            begin
                cur_next = nxt_rd;
                sc_we    = 1'b1;
                sc_wdata = nxt_rd;
            end
            OP_EVAL:
            begin
                priority if (status.take && status.hit_sink)
                begin
                    aug_bn_next = bn_min;
                    k_next      = '0;
                end
                else if (status.take && status.room)
                begin
                    pn_next   = tgt_rd;
                    pbn_next  = bn_min;
                    fst_raddr = tgt_rd;
                end
                else
                begin
                    cur_next = nxt_rd;
                    sc_we    = 1'b1;
                    sc_wdata = nxt_rd;
                end
            end
            OP_AUG_RD:
            begin
                sk_raddr = k_reg[NB-1:0];
            end
            OP_AUG_F1:
            begin
                e_next    = sc_rd[AB-1:0];
                flw_raddr = sc_rd[AB-1:0];
            end
            OP_AUG_F2:
            begin
                flw_we    = 1'b1;
                flw_waddr = e_reg;
                flw_wdata = flw_rd + aug_bn_reg;
                flw_raddr = e_reg ^ AB'(1);
            end
            OP_AUG_F3:
            begin
                flw_we    = 1'b1;
                flw_waddr = e_reg ^ AB'(1);
                flw_wdata = flw_rd - aug_bn_reg;
                k_next    = k_reg + SW'(1);
                if (status.aug_last)
                begin
                    flow_sum_next = sum_wide[FLOW_W] ? FLOW_MAX : sum_wide[FLOW_W-1:0];
                    visited_next  = visited_reg & ~clear_mask;
                end
            end
            OP_OUT:
            begin
                total_next     = flow_sum_reg;
                dropped_next   = overflow_reg;
                done_next      = 1'b1;
                arc_count_next = '0;
                valid_next     = '0;
                flow_sum_next  = '0;
                overflow_next  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 9'd256;
            source_reg     <= 8'd0;
            sink_reg       <= 8'd255;
            arc_count_reg  <= '0;
            flow_sum_reg   <= '0;
            overflow_reg   <= 1'b0;
            valid_reg      <= '0;
            visited_reg    <= '0;
            sp_reg         <= '0;
            k_reg          <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            sink_reg       <= sink_next;
            arc_count_reg  <= arc_count_next;
            flow_sum_reg   <= flow_sum_next;
            overflow_reg   <= overflow_next;
            valid_reg      <= valid_next;
            visited_reg    <= visited_next;
            sp_reg         <= sp_next;
            k_reg          <= k_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg    <= from_next;
        to_reg      <= to_next;
        cap_reg     <= cap_next;
        last_reg    <= last_next;
        cur_reg     <= cur_next;
        top_bn_reg  <= top_bn_next;
        pn_reg      <= pn_next;
        pbn_reg     <= pbn_next;
        aug_bn_reg  <= aug_bn_next;
        e_reg       <= e_next;
        total_reg   <= total_next;
        dropped_reg <= dropped_next;
    end

    mfd_ram #(.WIDTH(NB), .DEPTH(SLOTS)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(arc_waddr), .wdata(tgt_wdata),
        .raddr(arc_raddr), .rdata(tgt_rd)
    );
    mfd_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_cap (
        .clk(clk), .we(cap_we), .waddr(arc_waddr), .wdata(cap_wdata),
        .raddr(arc_raddr), .rdata(cap_rd)
    );
    mfd_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_flow (
        .clk(clk), .we(flw_we), .waddr(flw_waddr), .wdata(flw_wdata),
        .raddr(flw_raddr), .rdata(flw_rd)
    );
    mfd_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(nxt_raddr), .rdata(nxt_rd)
    );
    mfd_ram #(.WIDTH(AB), .DEPTH(NODE_LIMIT)) u_first (
        .clk(clk), .we(fst_we), .waddr(fst_waddr), .wdata(fst_wdata),
        .raddr(fst_raddr), .rdata(fst_rd)
    );
    mfd_ram #(.WIDTH(AB), .DEPTH(NODE_LIMIT)) u_last (
        .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
        .raddr(lst_raddr), .rdata(lst_rd)
    );
    mfd_ram #(.WIDTH(PW), .DEPTH(NODE_LIMIT)) u_stk_cur (
        .clk(clk), .we(sc_we), .waddr(sk_waddr), .wdata(sc_wdata),
        .raddr(sk_raddr), .rdata(sc_rd)
    );
    mfd_ram #(.WIDTH(FW), .DEPTH(NODE_LIMIT)) u_stk_bn (
        .clk(clk), .we(sb_we), .waddr(sk_waddr), .wdata(pbn_reg),
        .raddr(sk_raddr), .rdata(sb_rd)
    );

    assign done          = done_reg;
    assign total_flow    = total_reg;
    assign edges_dropped = dropped_reg;

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd == OP_OUT))
        else $error("result strobe without a result step");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SW'(NODE_LIMIT))
        else $error("stack pointer beyond node limit");

    a_arc_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        !arc_count_reg[0] && (arc_count_reg <= PW'(SLOTS)))
        else $error("arc count not a whole number of pairs within storage");

endmodule

FILE: bench/tb_max_flow_dfs_augment.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_flow_dfs_augment
// Loads edge words into the max-flow block, one graph per last-marked word, and
// checks each reported flow and drop flag against set values or a behavioural
// solver kept in step with every accepted word. Directed graphs first, including
// storage overflow, then random graphs over several register settings.
// ----------------------------------------------------------------------------
module tb_max_flow_dfs_augment;
    import mfd_pkg::*;

    localparam int NODES     = 256;
    localparam int ARC_SLOTS = 2048;
    localparam int ARC_NONE  = ARC_SLOTS;
    localparam int LIMIT     = 4000000;
    localparam int N_ITEMS   = 1600;

    typedef enum logic [1:0] {
        REG_NODE_COUNT = 2'd0,
        REG_SOURCE     = 2'd1,
        REG_SINK       = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic              dropped;
    } flow_word_t;

    typedef struct packed {
        logic [7:0]        src;
        logic [7:0]        dst;
        logic [15:0]       cap;
        logic              fin;
        logic              known;
        logic [FLOW_W-1:0] flow;
        logic              dropped;
    } edge_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [7:0]        edge_from;
    logic [7:0]        edge_to;
    logic [15:0]       edge_capacity;
    logic              last_edge;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [8:0]        cfg_data;
    logic              done;
    logic [FLOW_W-1:0] total_flow;
    logic              edges_dropped;

    max_flow_dfs_augment DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .edge_from     (edge_from),
        .edge_to       (edge_to),
        .edge_capacity (edge_capacity),
        .last_edge     (last_edge),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .total_flow    (total_flow),
        .edges_dropped (edges_dropped)
    );

    // solver state
    int  arc_to   [ARC_SLOTS];
    int  arc_cap  [ARC_SLOTS];
    int  arc_flw  [ARC_SLOTS];
    int  arc_nxt  [ARC_SLOTS];
    int  head_arc [NODES];
    int  tail_arc [NODES];
    bit  seen     [NODES];
    int  stk_cur  [NODES];
    int  stk_bn   [NODES];
    int  n_arcs;
    bit  storage_full;
    int  cur_nodes;
    int  cur_src;
    int  cur_snk;

    flow_word_t flow_q[$];
    int errors;
    int n_sent;
    int n_flows;
    int n_drop_flows;
    int cycles;
    bit quiet_tail;

    edge_row_t rows[13] = '{
        '{8'd0,   8'd255, 16'hffff, 1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd0,   8'd255, 16'hffff, 1'b1, 1'b1, 26'd131070, 1'b0},
        '{8'd0,   8'd255, 16'h0000, 1'b1, 1'b1, 26'd0,      1'b0},
        '{8'd255, 8'd0,   16'hffff, 1'b1, 1'b1, 26'd0,      1'b0},
        '{8'd0,   8'd1,   16'd7,    1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd1,   8'd255, 16'd3,    1'b1, 1'b1, 26'd3,      1'b0},
        '{8'd0,   8'd0,   16'd5,    1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd0,   8'd255, 16'd1,    1'b1, 1'b1, 26'd1,      1'b0},
        '{8'd0,   8'd1,   16'd10,   1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd0,   8'd2,   16'd10,   1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd1,   8'd2,   16'd5,    1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd2,   8'd255, 16'd12,   1'b0, 1'b0, 26'd0,      1'b0},
        '{8'd1,   8'd255, 16'd4,    1'b1, 1'b0, 26'd0,      1'b0}
    };

    function automatic void empty_graph();
        for (int i = 0; i < NODES; i++)
            head_arc[i] = ARC_NONE;
        n_arcs = 0;
        storage_full = 0;
    endfunction

    function automatic void unmark_nodes();
        int lim;
        lim = (cur_nodes < NODES) ? cur_nodes : NODES;
        for (int i = 0; i < lim; i++)
            seen[i] = 0;
    endfunction

    function automatic void link_arc(int node, int a, int tgt, int cap);
        arc_to[a]  = tgt;
        arc_cap[a] = cap;
        arc_flw[a] = 0;
        arc_nxt[a] = ARC_NONE;
        if (head_arc[node] == ARC_NONE)
            head_arc[node] = a;
        else
            arc_nxt[tail_arc[node]] = a;
        tail_arc[node] = a;
    endfunction

    // one depth-first search; returns the bottleneck pushed along the path
    function automatic int seek_path();
        int sp;
        int top;
        int a;
        int resid;
        int v;
        int bn;
        sp = 1;
        stk_cur[0] = head_arc[cur_src];
        stk_bn[0] = 32'h7fffffff;
        seen[cur_src] = 1;
        while (sp > 0) begin
            top = sp - 1;
            a = stk_cur[top];
            if (a >= ARC_NONE) begin
                sp--;
                if (sp > 0)
                    stk_cur[sp-1] = arc_nxt[stk_cur[sp-1]];
                continue;
            end
            resid = arc_cap[a] - arc_flw[a];
            v = arc_to[a];
            if (resid > 0 && !seen[v]) begin
                bn = (resid < stk_bn[top]) ? resid : stk_bn[top];
                if (v == cur_snk) begin
                    for (int k = 0; k <= top; k++) begin
                        arc_flw[stk_cur[k]] += bn;
                        arc_flw[stk_cur[k] ^ 1] -= bn;
                    end
                    return bn;
                end
                if (sp < NODES) begin
                    stk_cur[sp] = head_arc[v];
                    stk_bn[sp] = bn;
                    seen[v] = 1;
                    sp++;
                    continue;
                end
            end
            stk_cur[top] = arc_nxt[a];
        end
        return 0;
    endfunction

    // stores one edge when there is room; on the last one solves and returns the flow word
    function automatic bit solve_edge(input logic [7:0] f, input logic [7:0] t,
                                      input logic [15:0] c, input logic fin,
                                      output flow_word_t res);
        int df;
        longint sum;
        res = '0;
        if (n_arcs + 2 <= ARC_SLOTS) begin
            link_arc(f, n_arcs, t, c);
            link_arc(t, n_arcs + 1, f, 0);
            n_arcs += 2;
        end else begin
            storage_full = 1;
        end
        if (!fin)
            return 0;
        sum = 0;
        if (cur_src != cur_snk) begin
            unmark_nodes();
            df = seek_path();
            while (df > 0) begin
                sum += df;
                if (sum > 26'h3ffffff)
                    sum = 26'h3ffffff;
                unmark_nodes();
                df = seek_path();
            end
        end
        res.flow = sum[FLOW_W-1:0];
        res.dropped = storage_full;
        empty_graph();
        return 1;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout with %0d flow words outstanding", $time, flow_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: every done word must match the oldest expected flow
    always @(posedge clk)
    begin
        flow_word_t want;
        if (rst_n && done)
        begin
            if (flow_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected flow word flow=%0d dropped=%0d",
                         $time, total_flow, edges_dropped);
            end
            else
            begin
                want = flow_q.pop_front();
                n_flows++;
                if (want.dropped)
                    n_drop_flows++;
                if (total_flow !== want.flow)
                begin
                    errors++;
                    $display("%0t: total_flow expected %0d actual %0d",
                             $time, want.flow, total_flow);
                end
                if (edges_dropped !== want.dropped)
                begin
                    errors++;
                    $display("%0t: edges_dropped expected %0d actual %0d",
                             $time, want.dropped, edges_dropped);
                end
            end
        end
    end

    // called at a rising edge; start stays high when words follow back to back
    task automatic send_edge(input logic [7:0] f, input logic [7:0] t,
                             input logic [15:0] c, input logic fin,
                             input bit known, input flow_word_t fixed);
        flow_word_t res;
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        edge_from     <= f;
        edge_to       <= t;
        edge_capacity <= c;
        last_edge     <= fin;
        do
            @(posedge clk);
        while (busy);
        n_sent++;
        if (solve_edge(f, t, c, fin, res))
            flow_q.insert(flow_q.size(), known ? fixed : res);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (flow_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(input int nodes, input int src, input int snk);
        cfg_write <= 1'b1;
        cfg_index <= REG_NODE_COUNT;
        cfg_data  <= nodes[8:0];
        @(posedge clk);
        cfg_index <= REG_SOURCE;
        cfg_data  <= src[8:0];
        @(posedge clk);
        cfg_index <= REG_SINK;
        cfg_data  <= snk[8:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_nodes = nodes & 9'h1ff;
        cur_src   = src & 8'hff;
        cur_snk   = snk & 8'hff;
    endtask

    // one random graph, usually over a small pool of nodes that holds source and sink
    task automatic send_graph();
        logic [7:0] pool[8];
        int n_pool;
        int n_edges;
        bit noisy;
        logic [7:0] f;
        logic [7:0] t;
        logic [15:0] c;
        n_pool = $urandom_range(2, 8);
        pool[0] = 8'(cur_src);
        pool[1] = 8'(cur_snk);
        for (int i = 2; i < 8; i++)
            pool[i] = 8'($urandom_range(0, 255));
        n_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        noisy = ($urandom_range(0, 9) == 0);
        for (int e = 0; e < n_edges; e++)
        begin
            f = noisy ? 8'($urandom_range(0, 255)) : pool[$urandom_range(0, n_pool - 1)];
            t = noisy ? 8'($urandom_range(0, 255)) : pool[$urandom_range(0, n_pool - 1)];
            // wide capacities only on short graphs so the search count stays low
            if (n_edges <= 3)
                c = 16'($urandom_range(0, 65535));
            else if ($urandom_range(0, 3) == 0)
                c = 16'($urandom_range(0, 255));
            else
                c = 16'($urandom_range(0, 15));
            send_edge(f, t, c, e == n_edges - 1, 0, '0);
        end
    endtask

    initial
    begin
        int cfg_set[7][3];
        flow_word_t fixed;
        int base;
        cfg_set = '{'{256, 0, 255}, '{511, 17, 200}, '{256, 40, 40}, '{300, 255, 0},
                    '{256, 128, 127}, '{9, 3, 7}, '{2, 0, 1}};
        errors = 0;
        n_sent = 0;
        n_flows = 0;
        n_drop_flows = 0;
        cycles = 0;
        quiet_tail = 0;
        rst_n = 1'b0;
        start = 1'b0;
        edge_from = '0;
        edge_to = '0;
        edge_capacity = '0;
        last_edge = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_NODE_COUNT;
        cfg_data = '0;
        for (int i = 0; i < NODES; i++)
            seen[i] = 0;
        cur_nodes = 256;
        cur_src = 0;
        cur_snk = 255;
        empty_graph();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed graphs under the reset settings
        foreach (rows[i])
        begin
            fixed.flow = rows[i].flow;
            fixed.dropped = rows[i].dropped;
            send_edge(rows[i].src, rows[i].dst, rows[i].cap, rows[i].fin,
                      rows[i].known, fixed);
        end
        // storage overflow: more pairs than slots, none reachable from source
        fixed.flow = 0;
        fixed.dropped = 1'b1;
        for (int e = 0; e < 1030; e++)
            send_edge(8'd1, 8'd2, 16'd1, e == 1029, 1, fixed);
        fixed.flow = 65535;
        fixed.dropped = 1'b0;
        send_edge(8'd0, 8'd255, 16'hffff, 1'b1, 1, fixed);
        settle();

        // random graphs, narrow node counts last since they leave marks behind
        base = n_sent;
        foreach (cfg_set[p])
        begin
            set_regs(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2]);
            @(posedge clk);
            while (n_sent < base + ((N_ITEMS - base) * (p + 1)) / 7)
            begin
                quiet_tail = (p == 6) && (n_sent > base + ((N_ITEMS - base) * 9) / 10);
                send_graph();
            end
            settle();
        end

        $display("edge words sent: %0d, flow words checked: %0d (%0d with dropped edges)",
                 n_sent, n_flows, n_drop_flows);
        $display("register settings covered: reset plus %0d, including source equal to sink",
                 7);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
src/mfd_pkg.sv
src/mfd_ram.sv
src/mfd_ctrl.sv
src/mfd_dp.sv
src/max_flow_dfs_augment.sv
bench/tb_max_flow_dfs_augment.sv
